// File: rtl/pts_pkg.sv
package pts_pkg;

    localparam logic [8:0] NoPriority = 9'd256;

    typedef enum logic [3:0] {
        K_TICK         = 4'd0,
        K_ADD_THREAD   = 4'd1,
        K_ADD_PERIODIC = 4'd2,
        K_SLEEP        = 4'd3,
        K_KILL_ID      = 4'd4,
        K_KILL_SELF    = 4'd5,
        K_KILL_ALL     = 4'd6,
        K_SET_BLOCKED  = 4'd7,
        K_SCHEDULE     = 4'd8,
        K_LAUNCH       = 4'd9
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_LIMIT     = 3'd1,
        ST_NO_FREE   = 3'd2,
        ST_LAST      = 3'd3,
        ST_NO_THREAD = 3'd4
    } t_status;

    typedef enum logic {
        RK_EVENT = 1'b0,
        RK_DONE  = 1'b1
    } t_result_kind;

    typedef enum logic [1:0] {
        SC_WAKE,
        SC_SCHED,
        SC_LAUNCH,
        SC_KILL
    } t_scan;

    typedef enum logic [3:0] {
        S_IDLE,
        S_APPLY,
        S_EVENT,
        S_WAKE,
        S_SCHED,
        S_LAUNCH,
        S_KILL,
        S_RID,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [3:0]  kind;
        logic [7:0]  priority_req;
        logic [31:0] duration;
        logic [31:0] period;
        logic [31:0] target_id;
        logic [2:0]  target_slot;
        logic        block_value;
    } t_in_item;

    typedef struct packed {
        logic        result_kind;
        logic [1:0]  event_index;
        logic [2:0]  status;
        logic [2:0]  running_slot;
        logic [31:0] running_id;
        logic [31:0] new_id;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic  load;
        logic  apply;
        logic  ev_emit;
        logic  ev_skip;
        logic  scan_start;
        t_scan scan_sel;
        logic  emit_done;
    } t_cmd;

    typedef struct packed {
        logic [3:0] kind;
        logic       live_one;
        logic       self_ok;
        logic       ev_end;
        logic       ev_due;
        logic       scan_done;
        logic       kill_found;
        logic       out_free;
    } t_sts;

endpackage

// File: rtl/priority_thread_scheduler.sv
// channel  direction  valid        stall        beat
// in       input      i_in_valid   o_in_stall   i_in_data  (pts_pkg::t_in_item)
// out      output     o_out_valid  i_out_stall  o_out_data (pts_pkg::t_out_item)
//
// One command at a time: the input stalls from load until the done beat is emitted.
// Slot scans read the slots in turn through the single read port of the slot table.
// A tick emits due event beats, then runs a wake scan and a schedule scan.
// Reset is synchronous, active low; clears flags and counters, not slot/event tables.
// A stalled output beat holds; event beats wait for the output register.
module priority_thread_scheduler #(
    parameter int unsigned THREAD_SLOTS = 8,
    parameter int unsigned EVENT_SLOTS  = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  pts_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output pts_pkg::t_out_item o_out_data
);

    pts_pkg::t_cmd cmd;
    pts_pkg::t_sts sts;

    pts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    pts_datapath #(
        .THREAD_SLOTS (THREAD_SLOTS),
        .EVENT_SLOTS  (EVENT_SLOTS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .i_out_stall (i_out_stall),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

// File: rtl/pts_ctrl.sv
module pts_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  pts_pkg::t_sts i_sts,
    output pts_pkg::t_cmd o_cmd,
    output logic          o_in_stall
);

    pts_pkg::t_state r_state;
    pts_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pts_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_cmd.scan_sel = pts_pkg::SC_WAKE;
        case (r_state)
            pts_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = pts_pkg::S_APPLY;
                end
            end
            pts_pkg::S_APPLY: begin
                o_cmd.apply = 1'b1;
                case (i_sts.kind)
                    pts_pkg::K_TICK: begin
                        n_state = pts_pkg::S_EVENT;
                    end
                    pts_pkg::K_SLEEP, pts_pkg::K_SCHEDULE: begin
                        o_cmd.scan_start = 1'b1;
                        o_cmd.scan_sel = pts_pkg::SC_SCHED;
                        n_state = pts_pkg::S_SCHED;
                    end
                    pts_pkg::K_KILL_ID: begin
                        if (i_sts.live_one) begin
                            n_state = pts_pkg::S_RID;
                        end else begin
                            o_cmd.scan_start = 1'b1;
                            o_cmd.scan_sel = pts_pkg::SC_KILL;
                            n_state = pts_pkg::S_KILL;
                        end
                    end
                    pts_pkg::K_KILL_SELF: begin
                        if (i_sts.self_ok) begin
                            o_cmd.scan_start = 1'b1;
                            o_cmd.scan_sel = pts_pkg::SC_SCHED;
                            n_state = pts_pkg::S_SCHED;
                        end else begin
                            n_state = pts_pkg::S_RID;
                        end
                    end
                    pts_pkg::K_LAUNCH: begin
                        o_cmd.scan_start = 1'b1;
                        o_cmd.scan_sel = pts_pkg::SC_LAUNCH;
                        n_state = pts_pkg::S_LAUNCH;
                    end
                    default: begin
                        n_state = pts_pkg::S_RID;
                    end
                endcase
            end
            pts_pkg::S_EVENT: begin
                if (i_sts.ev_end) begin
                    o_cmd.scan_start = 1'b1;
                    o_cmd.scan_sel = pts_pkg::SC_WAKE;
                    n_state = pts_pkg::S_WAKE;
                end else if (!i_sts.ev_due) begin
                    o_cmd.ev_skip = 1'b1;
                end else if (i_sts.out_free) begin
                    o_cmd.ev_emit = 1'b1;
                end
            end
            pts_pkg::S_WAKE: begin
                if (i_sts.scan_done) begin
                    o_cmd.scan_start = 1'b1;
                    o_cmd.scan_sel = pts_pkg::SC_SCHED;
                    n_state = pts_pkg::S_SCHED;
                end
            end
            pts_pkg::S_KILL: begin
                if (i_sts.scan_done) begin
                    if (i_sts.kill_found) begin
                        o_cmd.scan_start = 1'b1;
                        o_cmd.scan_sel = pts_pkg::SC_SCHED;
                        n_state = pts_pkg::S_SCHED;
                    end else begin
                        n_state = pts_pkg::S_RID;
                    end
                end
            end
            pts_pkg::S_SCHED, pts_pkg::S_LAUNCH: begin
                if (i_sts.scan_done) begin
                    n_state = pts_pkg::S_RID;
                end
            end
            pts_pkg::S_RID: begin
                n_state = pts_pkg::S_DONE;
            end
            pts_pkg::S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_done = 1'b1;
                    n_state = pts_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pts_pkg::S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != pts_pkg::S_IDLE);

endmodule

// File: rtl/pts_datapath.sv
module pts_datapath #(
    parameter int unsigned THREAD_SLOTS = 8,
    parameter int unsigned EVENT_SLOTS  = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pts_pkg::t_in_item  i_in_data,
    input  pts_pkg::t_cmd      i_cmd,
    input  logic               i_out_stall,
    output pts_pkg::t_sts      o_sts,
    output logic               o_out_valid,
    output pts_pkg::t_out_item o_out_data
);

    localparam int unsigned SW  = $clog2(THREAD_SLOTS);
    localparam int unsigned LW  = $clog2(THREAD_SLOTS + 1);
    localparam int unsigned EW  = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1;
    localparam int unsigned ECW = $clog2(EVENT_SLOTS + 1);
    localparam logic [SW:0]    SlotsW   = (SW + 1)'(THREAD_SLOTS);
    localparam logic [SW-1:0]  LastSlot = SW'(THREAD_SLOTS - 1);
    localparam logic [LW-1:0]  LiveMax  = LW'(THREAD_SLOTS);
    localparam logic [LW-1:0]  LiveOne  = LW'(1);
    localparam logic [ECW-1:0] EvMax    = ECW'(EVENT_SLOTS);

    pts_pkg::t_in_item r_item;

    logic [THREAD_SLOTS-1:0] r_alive;
    logic [THREAD_SLOTS-1:0] r_asleep;
    logic [THREAD_SLOTS-1:0] r_blocked;
    logic [7:0]              r_pri_mem  [THREAD_SLOTS];
    logic [15:0]             r_ser_mem  [THREAD_SLOTS];
    logic [31:0]             r_wake_mem [THREAD_SLOTS];
    logic [7:0]              r_rd_pri;
    logic [15:0]             r_rd_ser;
    logic [31:0]             r_rd_wake;

    logic [31:0] r_ev_period [EVENT_SLOTS];
    logic [31:0] r_ev_due    [EVENT_SLOTS];

    logic [31:0]    r_tick;
    logic [LW-1:0]  r_live;
    logic [ECW-1:0] r_ev_cnt;
    logic [ECW-1:0] r_ev_idx;
    logic [15:0]    r_serial;
    logic [SW-1:0]  r_cur;

    logic           r_scan_run;
    pts_pkg::t_scan r_scan_sel;
    logic [SW-1:0]  r_scan_k;
    logic           r_q_vld;
    logic           r_q_last;
    logic [SW-1:0]  r_q_slot;
    logic [8:0]     r_best;
    logic [SW-1:0]  r_pick;
    logic           r_found;

    pts_pkg::t_status r_status;
    logic [1:0]       r_idx_out;
    logic [31:0]      r_new_id;

    logic               r_out_valid;
    pts_pkg::t_out_item r_out;

    logic          free_found;
    logic [SW-1:0] free_slot;
    logic          add_ok;
    logic          live_one;
    logic          self_ok;
    logic [SW:0]   sched_sum;
    logic [SW:0]   sched_wrap;
    logic [SW-1:0] issue_slot;
    logic [SW-1:0] rd_addr;
    logic          q_alive;
    logic          q_asleep;
    logic          q_blocked;
    logic          cand;
    logic          wake_hit;
    logic          kill_hit;
    logic          scan_done;
    logic [EW-1:0] ev_sel;
    logic [EW-1:0] ev_new;
    logic          ev_end;
    logic          ev_due;
    logic          blk_ok;
    logic [SW-1:0] blk_idx;
    logic          out_free;
    logic          out_load;
    logic [THREAD_SLOTS-1:0] cur_mask;

    logic          wake_we;
    logic [SW-1:0] wake_wa;
    logic [31:0]   wake_wd;

    always_comb begin
        free_found = 1'b0;
        free_slot = '0;
        for (int i = THREAD_SLOTS - 1; i >= 0; i--) begin
            if (!r_alive[i]) begin
                free_found = 1'b1;
                free_slot = SW'(i);
            end
        end
    end

    assign add_ok   = (r_live < LiveMax) && free_found;
    assign live_one = (r_live == LiveOne);
    assign self_ok  = !live_one && r_alive[r_cur];
    assign cur_mask = THREAD_SLOTS'(1) << r_cur;

    assign sched_sum  = {1'b0, r_cur} + {1'b0, r_scan_k} + (SW + 1)'(1);
    assign sched_wrap = (sched_sum >= SlotsW) ? (sched_sum - SlotsW) : sched_sum;
    assign issue_slot = (r_scan_sel == pts_pkg::SC_SCHED) ? sched_wrap[SW-1:0] : r_scan_k;
    assign rd_addr    = r_scan_run ? issue_slot : r_cur;

    assign q_alive   = r_alive[r_q_slot];
    assign q_asleep  = r_asleep[r_q_slot];
    assign q_blocked = r_blocked[r_q_slot];

    always_comb begin
        case (r_scan_sel)
            pts_pkg::SC_SCHED:
                cand = q_alive && !q_asleep && !q_blocked && ({1'b0, r_rd_pri} < r_best);
            pts_pkg::SC_LAUNCH:
                cand = q_alive && ({1'b0, r_rd_pri} < r_best);
            default:
                cand = 1'b0;
        endcase
    end

    assign wake_hit = (r_scan_sel == pts_pkg::SC_WAKE) && q_asleep && (r_rd_wake <= r_tick);
    assign kill_hit = (r_scan_sel == pts_pkg::SC_KILL) && !r_found && q_alive
                      && ({r_rd_ser, 16'(r_q_slot)} == r_item.target_id);
    assign scan_done = r_q_vld && r_q_last;

    assign ev_sel = r_ev_idx[EW-1:0];
    assign ev_new = r_ev_cnt[EW-1:0];
    assign ev_end = (r_ev_idx >= r_ev_cnt);
    assign ev_due = (r_ev_due[ev_sel] <= r_tick);

    assign blk_ok  = (32'(r_item.target_slot) < THREAD_SLOTS);
    assign blk_idx = SW'(r_item.target_slot);

    assign out_free = !r_out_valid || !i_out_stall;
    assign out_load = i_cmd.ev_emit || i_cmd.emit_done;

    always_comb begin
        wake_we = 1'b0;
        wake_wa = r_q_slot;
        wake_wd = '0;
        if (i_cmd.apply && (r_item.kind == pts_pkg::K_SLEEP)) begin
            wake_we = 1'b1;
            wake_wa = r_cur;
            wake_wd = r_item.duration + r_tick;
        end else if (i_cmd.apply && (r_item.kind == pts_pkg::K_ADD_THREAD) && add_ok) begin
            wake_we = 1'b1;
            wake_wa = free_slot;
        end else if (r_q_vld && wake_hit) begin
            wake_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alive     <= '0;
            r_asleep    <= '0;
            r_blocked   <= '0;
            r_tick      <= '0;
            r_live      <= '0;
            r_ev_cnt    <= '0;
            r_ev_idx    <= '0;
            r_serial    <= '0;
            r_cur       <= '0;
            r_scan_run  <= 1'b0;
            r_scan_sel  <= pts_pkg::SC_WAKE;
            r_scan_k    <= '0;
            r_q_vld     <= 1'b0;
            r_q_last    <= 1'b0;
            r_q_slot    <= '0;
            r_best      <= pts_pkg::NoPriority;
            r_pick      <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_ev_idx <= '0;
            end else if (i_cmd.ev_emit || i_cmd.ev_skip) begin
                r_ev_idx <= r_ev_idx + ECW'(1);
            end

            if (i_cmd.apply) begin
                case (r_item.kind)
                    pts_pkg::K_TICK: begin
                        r_tick <= r_tick + 32'd1;
                    end
                    pts_pkg::K_ADD_THREAD: begin
                        if (add_ok) begin
                            r_alive[free_slot]   <= 1'b1;
                            r_asleep[free_slot]  <= 1'b0;
                            r_blocked[free_slot] <= 1'b0;
                            r_serial <= r_serial + 16'd1;
                            r_live   <= r_live + LW'(1);
                        end
                    end
                    pts_pkg::K_ADD_PERIODIC: begin
                        if (r_ev_cnt < EvMax) begin
                            r_ev_cnt <= r_ev_cnt + ECW'(1);
                        end
                    end
                    pts_pkg::K_SLEEP: begin
                        r_asleep[r_cur] <= 1'b1;
                    end
                    pts_pkg::K_KILL_SELF: begin
                        if (self_ok) begin
                            r_alive[r_cur] <= 1'b0;
                            r_live <= r_live - LW'(1);
                        end
                    end
                    pts_pkg::K_KILL_ALL: begin
                        r_alive <= r_alive & cur_mask;
                        r_live  <= r_alive[r_cur] ? LiveOne : '0;
                    end
                    pts_pkg::K_SET_BLOCKED: begin
                        if (blk_ok) begin
                            r_blocked[blk_idx] <= r_item.block_value;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            r_q_vld  <= r_scan_run;
            r_q_last <= r_scan_run && (r_scan_k == LastSlot);
            r_q_slot <= issue_slot;

            if (r_q_vld) begin
                if (cand) begin
                    r_best <= {1'b0, r_rd_pri};
                    r_pick <= r_q_slot;
                end
                if (wake_hit) begin
                    r_asleep[r_q_slot] <= 1'b0;
                end
                if (kill_hit) begin
                    r_found <= 1'b1;
                    r_alive[r_q_slot] <= 1'b0;
                    r_live <= r_live - LW'(1);
                end
                if (r_q_last && ((r_scan_sel == pts_pkg::SC_SCHED)
                                 || (r_scan_sel == pts_pkg::SC_LAUNCH))) begin
                    r_cur <= cand ? r_q_slot : r_pick;
                end
            end

            if (i_cmd.scan_start) begin
                r_scan_run <= 1'b1;
                r_scan_sel <= i_cmd.scan_sel;
                r_scan_k   <= '0;
                r_found    <= 1'b0;
                r_best     <= pts_pkg::NoPriority;
                r_pick     <= (i_cmd.scan_sel == pts_pkg::SC_LAUNCH) ? '0 : r_cur;
            end else if (r_scan_run) begin
                r_scan_k <= r_scan_k + SW'(1);
                if (r_scan_k == LastSlot) begin
                    r_scan_run <= 1'b0;
                end
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_pri  <= r_pri_mem[rd_addr];
        r_rd_ser  <= r_ser_mem[rd_addr];
        r_rd_wake <= r_wake_mem[rd_addr];
        if (wake_we) begin
            r_wake_mem[wake_wa] <= wake_wd;
        end

        if (i_cmd.load) begin
            r_item    <= i_in_data;
            r_status  <= pts_pkg::ST_OK;
            r_idx_out <= '0;
            r_new_id  <= '0;
        end

        if (i_cmd.apply) begin
            case (r_item.kind)
                pts_pkg::K_ADD_THREAD: begin
                    if (r_live >= LiveMax) begin
                        r_status <= pts_pkg::ST_LIMIT;
                    end else if (!free_found) begin
                        r_status <= pts_pkg::ST_NO_FREE;
                    end else begin
                        r_new_id <= {r_serial, 16'(free_slot)};
                        r_pri_mem[free_slot] <= r_item.priority_req;
                        r_ser_mem[free_slot] <= r_serial;
                    end
                end
                pts_pkg::K_ADD_PERIODIC: begin
                    if (r_ev_cnt >= EvMax) begin
                        r_status <= pts_pkg::ST_LIMIT;
                    end else begin
                        r_ev_period[ev_new] <= r_item.period;
                        r_ev_due[ev_new]    <= r_tick + r_item.period;
                        r_idx_out           <= 2'(r_ev_cnt);
                    end
                end
                pts_pkg::K_KILL_ID: begin
                    if (live_one) begin
                        r_status <= pts_pkg::ST_LAST;
                    end
                end
                pts_pkg::K_KILL_SELF: begin
                    if (live_one) begin
                        r_status <= pts_pkg::ST_LAST;
                    end else if (!r_alive[r_cur]) begin
                        r_status <= pts_pkg::ST_NO_THREAD;
                    end
                end
                default: begin
                end
            endcase
        end

        if (scan_done && (r_scan_sel == pts_pkg::SC_KILL) && !(r_found || kill_hit)) begin
            r_status <= pts_pkg::ST_NO_THREAD;
        end

        if (i_cmd.ev_emit) begin
            r_ev_due[ev_sel] <= r_tick + r_ev_period[ev_sel];
            r_out <= '{result_kind:  pts_pkg::RK_EVENT,
                       event_index:  2'(r_ev_idx),
                       status:       pts_pkg::ST_OK,
                       running_slot: 3'd0,
                       running_id:   32'd0,
                       new_id:       32'd0,
                       last:         1'b0};
        end else if (i_cmd.emit_done) begin
            r_out <= '{result_kind:  pts_pkg::RK_DONE,
                       event_index:  r_idx_out,
                       status:       r_status,
                       running_slot: 3'(r_cur),
                       running_id:   r_alive[r_cur] ? {r_rd_ser, 16'(r_cur)} : 32'd0,
                       new_id:       r_new_id,
                       last:         1'b1};
        end
    end

    assign o_sts = '{kind:       r_item.kind,
                     live_one:   live_one,
                     self_ok:    self_ok,
                     ev_end:     ev_end,
                     ev_due:     ev_due,
                     scan_done:  scan_done,
                     kill_found: r_found || kill_hit,
                     out_free:   out_free};

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_live_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live == LW'($countones(r_alive)))
        else $error("live thread count differs from live slots");

    a_cur_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_cur} < SlotsW)
        else $error("current slot out of range");

    a_ev_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ev_cnt <= EvMax)
        else $error("event count beyond table");

    a_scan_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_q_last |-> r_q_vld && !r_scan_run)
        else $error("scan end without a read in flight");

endmodule

// File: test/priority_thread_scheduler_test.sv
module priority_thread_scheduler_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOT = 8;
    localparam int NEVT = 4;
    localparam int CYCLE_LIMIT = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    pts_pkg::t_in_item i_in_data = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    pts_pkg::t_out_item o_out_data;

    priority_thread_scheduler dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data)
    );

    always #5 i_clk = ~i_clk;

    logic        alive [NSLOT];
    logic        asleep [NSLOT];
    logic        blocked [NSLOT];
    logic [7:0]  prio [NSLOT];
    logic [31:0] wake_at [NSLOT];
    logic [15:0] serial [NSLOT];
    logic [31:0] ev_period [NEVT];
    logic [31:0] ev_due [NEVT];
    logic [31:0] ticks;
    int unsigned live_cnt;
    int unsigned ev_cnt;
    logic [15:0] serial_next;
    logic [2:0]  cur;

    pts_pkg::t_out_item beats_due [$];
    int unsigned mismatches = 0;
    int unsigned cycles = 0;
    logic        quiet = 1'b0;

    function automatic logic [31:0] thread_id(int s);
        return {serial[s], 13'd0, 3'(s)};
    endfunction

    task automatic pick_next();
        logic [8:0] best;
        logic [2:0] pick;
        int s;
        best = pts_pkg::NoPriority;
        pick = cur;
        for (int k = 1; k <= NSLOT; k++) begin
            s = (int'(cur) + k) % NSLOT;
            if (alive[s] && !asleep[s] && !blocked[s] && {1'b0, prio[s]} < best) begin
                pick = 3'(s);
                best = {1'b0, prio[s]};
            end
        end
        cur = pick;
    endtask

    task automatic kill_thread(input logic [31:0] id, output pts_pkg::t_status st);
        st = pts_pkg::ST_NO_THREAD;
        if (live_cnt == 1) begin
            st = pts_pkg::ST_LAST;
            return;
        end
        for (int s = 0; s < NSLOT; s++) begin
            if (alive[s] && thread_id(s) == id) begin
                alive[s] = 1'b0;
                if (live_cnt > 0) live_cnt--;
                pick_next();
                st = pts_pkg::ST_OK;
                return;
            end
        end
    endtask

    task automatic clear_model();
        for (int s = 0; s < NSLOT; s++) begin
            alive[s] = 0; asleep[s] = 0; blocked[s] = 0;
            prio[s] = 0; wake_at[s] = 0; serial[s] = 0;
        end
        for (int e = 0; e < NEVT; e++) begin
            ev_period[e] = 0; ev_due[e] = 0;
        end
        ticks = 0; live_cnt = 0; ev_cnt = 0; serial_next = 0; cur = 0;
    endtask

    task automatic predict_command(input pts_pkg::t_in_item it);
        pts_pkg::t_out_item r;
        pts_pkg::t_status st;
        logic [1:0] idx;
        logic [31:0] nid;
        int s;
        logic [8:0] best;
        st = pts_pkg::ST_OK;
        idx = 0;
        nid = 0;
        case (it.kind)
            pts_pkg::K_TICK: begin
                ticks = ticks + 1;
                for (int e = 0; e < ev_cnt && e < NEVT; e++) begin
                    if (ev_due[e] <= ticks) begin
                        ev_due[e] = ticks + ev_period[e];
                        r = '0;
                        r.result_kind = pts_pkg::RK_EVENT;
                        r.event_index = 2'(e);
                        beats_due.push_back(r);
                    end
                end
                for (int k = 0; k < NSLOT; k++) begin
                    if (asleep[k] && wake_at[k] <= ticks) begin
                        asleep[k] = 0;
                        wake_at[k] = 0;
                    end
                end
                pick_next();
            end
            pts_pkg::K_ADD_THREAD: begin
                if (live_cnt >= NSLOT) st = pts_pkg::ST_LIMIT;
                else begin
                    s = NSLOT;
                    for (int k = NSLOT - 1; k >= 0; k--) if (!alive[k]) s = k;
                    if (s >= NSLOT) st = pts_pkg::ST_NO_FREE;
                    else begin
                        alive[s] = 1; asleep[s] = 0; blocked[s] = 0; wake_at[s] = 0;
                        prio[s] = it.priority_req;
                        serial[s] = serial_next;
                        serial_next = serial_next + 1;
                        live_cnt++;
                        nid = thread_id(s);
                    end
                end
            end
            pts_pkg::K_ADD_PERIODIC: begin
                if (ev_cnt >= NEVT) st = pts_pkg::ST_LIMIT;
                else begin
                    ev_period[ev_cnt] = it.period;
                    ev_due[ev_cnt] = ticks + it.period;
                    idx = 2'(ev_cnt);
                    ev_cnt++;
                end
            end
            pts_pkg::K_SLEEP: begin
                wake_at[cur] = it.duration + ticks;
                asleep[cur] = 1;
                pick_next();
            end
            pts_pkg::K_KILL_ID: kill_thread(it.target_id, st);
            pts_pkg::K_KILL_SELF: begin
                if (alive[cur]) kill_thread(thread_id(cur), st);
                else st = (live_cnt == 1) ? pts_pkg::ST_LAST : pts_pkg::ST_NO_THREAD;
            end
            pts_pkg::K_KILL_ALL: begin
                for (int k = 0; k < NSLOT; k++) if (k != cur) alive[k] = 0;
                live_cnt = alive[cur] ? 1 : 0;
            end
            pts_pkg::K_SET_BLOCKED: blocked[it.target_slot] = it.block_value;
            pts_pkg::K_SCHEDULE: pick_next();
            pts_pkg::K_LAUNCH: begin
                best = pts_pkg::NoPriority;
                cur = 0;
                for (int k = 0; k < NSLOT; k++) begin
                    if (alive[k] && {1'b0, prio[k]} < best) begin
                        best = {1'b0, prio[k]};
                        cur = 3'(k);
                    end
                end
            end
            default: ;
        endcase
        r = '0;
        r.result_kind = pts_pkg::RK_DONE;
        r.event_index = idx;
        r.status = st;
        r.running_slot = cur;
        r.running_id = alive[cur] ? thread_id(cur) : 32'd0;
        r.new_id = nid;
        r.last = 1'b1;
        beats_due.push_back(r);
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        mismatches++;
        $display("%0t: %s got %0h expected %0h", $realtime, what, got, want);
    endtask

    always @(posedge i_clk) begin
        pts_pkg::t_out_item w;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (beats_due.size() == 0) report("unexpected beat", o_out_data.status, 0);
            else begin
                w = beats_due.pop_front();
                if (o_out_data.result_kind !== w.result_kind)
                    report("result_kind", o_out_data.result_kind, w.result_kind);
                if (o_out_data.event_index !== w.event_index)
                    report("event_index", o_out_data.event_index, w.event_index);
                if (o_out_data.status !== w.status)
                    report("status", o_out_data.status, w.status);
                if (o_out_data.running_slot !== w.running_slot)
                    report("running_slot", o_out_data.running_slot, w.running_slot);
                if (o_out_data.running_id !== w.running_id)
                    report("running_id", o_out_data.running_id, w.running_id);
                if (o_out_data.new_id !== w.new_id)
                    report("new_id", o_out_data.new_id, w.new_id);
                if (o_out_data.last !== w.last)
                    report("last", o_out_data.last, w.last);
            end
        end
    end

    int out_hold = 0;
    int out_run = 0;
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
        if (quiet) i_out_stall <= 1'b0;
        else if (out_hold > 0) begin
            out_hold--;
            i_out_stall <= 1'b1;
        end else if (out_run > 0) begin
            out_run--;
            i_out_stall <= 1'b0;
        end else if ($urandom_range(0, 3) == 0) begin
            out_hold = $urandom_range(0, 5);
            i_out_stall <= 1'b1;
        end else begin
            out_run = $urandom_range(0, 12);
            i_out_stall <= 1'b0;
        end
    end

    task automatic send(input pts_pkg::t_in_item it, input logic [2:0] want_status,
                        input logic check_status);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_command(it);
        if (check_status && beats_due[$].status != want_status)
            report("directed status", beats_due[$].status, want_status);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (beats_due.size() != 0) @(posedge i_clk);
    endtask

    function automatic pts_pkg::t_in_item make_cmd(pts_pkg::t_kind k, logic [7:0] p,
                                                   logic [31:0] d, logic [31:0] per,
                                                   logic [31:0] id, logic [2:0] ts,
                                                   logic bv);
        pts_pkg::t_in_item it;
        it.kind = k; it.priority_req = p; it.duration = d; it.period = per;
        it.target_id = id; it.target_slot = ts; it.block_value = bv;
        return it;
    endfunction

    typedef struct {
        pts_pkg::t_in_item cmd;
        logic              check;
        logic [2:0]        want;
    } t_row;

    t_row plan [$];

    function automatic pts_pkg::t_in_item random_cmd();
        pts_pkg::t_in_item it;
        int sel;
        it.kind = 4'($urandom_range(0, 9));
        sel = $urandom_range(0, 19);
        if (sel == 0) it.kind = 4'($urandom_range(10, 15));
        it.priority_req = 8'($urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, 6));
        it.duration = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 4);
        it.period = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 5);
        if ($urandom_range(0, 2) != 0) begin
            it.target_id = thread_id($urandom_range(0, NSLOT - 1));
        end else it.target_id = $urandom;
        it.target_slot = 3'($urandom);
        it.block_value = $urandom_range(0, 3) == 0;
        if (it.kind == pts_pkg::K_KILL_ALL && $urandom_range(0, 2) != 0)
            it.kind = pts_pkg::K_SCHEDULE;
        return it;
    endfunction

    initial begin
        pts_pkg::t_in_item it;
        clear_model();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        plan.push_back('{make_cmd(pts_pkg::K_SCHEDULE, 0, 0, 0, 0, 0, 0), 1, pts_pkg::ST_OK});
        plan.push_back('{make_cmd(pts_pkg::K_KILL_SELF, 0, 0, 0, 0, 0, 0), 1,
                         pts_pkg::ST_NO_THREAD});
        plan.push_back('{make_cmd(pts_pkg::K_LAUNCH, 0, 0, 0, 0, 0, 0), 1, pts_pkg::ST_OK});
        plan.push_back('{make_cmd(pts_pkg::K_ADD_THREAD, 8'hff, 0, 0, 0, 0, 0), 1,
                         pts_pkg::ST_OK});
        plan.push_back('{make_cmd(pts_pkg::K_KILL_SELF, 0, 0, 0, 0, 0, 0), 1,
                         pts_pkg::ST_LAST});
        plan.push_back('{make_cmd(pts_pkg::K_ADD_THREAD, 8'h00, 0, 0, 0, 0, 0), 1,
                         pts_pkg::ST_OK});
        for (int k = 0; k < 6; k++)
            plan.push_back('{make_cmd(pts_pkg::K_ADD_THREAD, 8'(k + 1), 0, 0, 0, 0, 0), 1,
                             pts_pkg::ST_OK});
        plan.push_back('{make_cmd(pts_pkg::K_ADD_THREAD, 8'h05, 0, 0, 0, 0, 0), 1,
                         pts_pkg::ST_LIMIT});
        plan.push_back('{make_cmd(pts_pkg::K_ADD_PERIODIC, 0, 0, 32'd0, 0, 0, 0), 1,
                         pts_pkg::ST_OK});
        plan.push_back('{make_cmd(pts_pkg::K_ADD_PERIODIC, 0, 0, 32'd1, 0, 0, 0), 1,
                         pts_pkg::ST_OK});
        plan.push_back('{make_cmd(pts_pkg::K_ADD_PERIODIC, 0, 0, 32'hffffffff, 0, 0, 0), 1,
                         pts_pkg::ST_OK});
        plan.push_back('{make_cmd(pts_pkg::K_ADD_PERIODIC, 0, 0, 32'd2, 0, 0, 0), 1,
                         pts_pkg::ST_OK});
        plan.push_back('{make_cmd(pts_pkg::K_ADD_PERIODIC, 0, 0, 32'd3, 0, 0, 0), 1,
                         pts_pkg::ST_LIMIT});
        plan.push_back('{make_cmd(pts_pkg::K_LAUNCH, 0, 0, 0, 0, 0, 0), 0, 0});
        plan.push_back('{make_cmd(pts_pkg::K_SET_BLOCKED, 0, 0, 0, 0, 3'd2, 1), 0, 0});
        plan.push_back('{make_cmd(pts_pkg::K_SLEEP, 0, 32'hffffffff, 0, 0, 0, 0), 0, 0});
        plan.push_back('{make_cmd(pts_pkg::K_SLEEP, 0, 32'd0, 0, 0, 0, 0), 0, 0});
        plan.push_back('{make_cmd(pts_pkg::K_TICK, 0, 0, 0, 0, 0, 0), 0, 0});
        plan.push_back('{make_cmd(pts_pkg::K_KILL_ID, 0, 0, 0, 32'hffffffff, 0, 0), 1,
                         pts_pkg::ST_NO_THREAD});
        plan.push_back('{make_cmd(pts_pkg::K_KILL_ID, 0, 0, 0, 32'h00030003, 0, 0), 1,
                         pts_pkg::ST_OK});
        plan.push_back('{make_cmd(pts_pkg::K_KILL_SELF, 0, 0, 0, 0, 0, 0), 0, 0});
        plan.push_back('{make_cmd(pts_pkg::t_kind'(4'd15), 0, 0, 0, 0, 0, 0), 1,
                         pts_pkg::ST_OK});
        plan.push_back('{make_cmd(pts_pkg::K_KILL_ALL, 0, 0, 0, 0, 0, 0), 1, pts_pkg::ST_OK});

        foreach (plan[n]) send(plan[n].cmd, plan[n].want, plan[n].check);
        drain();

        for (int n = 0; n < 125; n++) begin
            if (n == 50) drain();
            if (n == 100) quiet = 1'b1;
            it = random_cmd();
            if ($urandom_range(0, 2) == 0) it.kind = pts_pkg::K_TICK;
            send(it, 0, 0);
        end
        it = make_cmd(pts_pkg::t_kind'(4'd10), 8'hff, 32'hffffffff, 32'hffffffff,
                      32'hffffffff, 3'd7, 1);
        send(it, 0, 0);
        drain();
        repeat (60) @(posedge i_clk);

        if (mismatches == 0 && beats_due.size() == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end
endmodule

// File: sim.f
rtl/pts_pkg.sv
rtl/pts_ctrl.sv
rtl/pts_datapath.sv
rtl/priority_thread_scheduler.sv
test/priority_thread_scheduler_test.sv
